// ===== hw/rtl/scfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfc_pkg
// Types, constants and the byte-wide CRC step shared by the servo command
// frame builder.
// ----------------------------------------------------------------------------
package scfc_pkg;

    // crc-16 settings: msb first, no reflection, no final xor
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    // frame layout
    localparam int FRAME_LEN    = 6;
    localparam int HDR_LEN      = 4;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [2:0] BYTE_CMD    = 3'd0;
    localparam logic [2:0] BYTE_ID     = 3'd1;
    localparam logic [2:0] BYTE_ARG_HI = 3'd2;
    localparam logic [2:0] BYTE_ARG_LO = 3'd3;
    localparam logic [2:0] BYTE_CRC_HI = 3'd4;
    localparam logic [2:0] BYTE_CRC_LO = 3'd5;

    typedef struct packed {
        logic [7:0]  command;
        logic [7:0]  servo_id;
        logic [15:0] argument;
    } t_in_item;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_out_item;

    // finished frame handed from front to back
    typedef struct packed {
        logic [7:0]  command;
        logic [7:0]  servo_id;
        logic [15:0] argument;
        logic [15:0] crc;
    } t_frame;

    // handshake between two stages
    typedef struct packed {
        logic valid;
        logic ready;
    } t_link;

    // one byte of crc, eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/scfc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfc_front
// Accepts one command item and runs the crc over its four header bytes,
// one byte per cycle, then hands the finished frame to the queue.
// ----------------------------------------------------------------------------
module scfc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  scfc_pkg::t_in_item i_item,
    output scfc_pkg::t_frame  o_frame,
    output scfc_pkg::t_link   o_link_valid,
    input  scfc_pkg::t_link   i_link_ready
);
    import scfc_pkg::*;

    logic            r_busy, n_busy;
    logic [1:0]      r_cnt, n_cnt;
    logic [15:0]     r_crc, n_crc;
    t_in_item        r_item, n_item;

    logic [7:0]      w_byte;
    logic [15:0]     w_crc_next;
    logic            w_done;
    logic            w_push_q;
    logic            w_accept;

    // header byte for the current crc step
    always_comb begin
        case ({1'b0, r_cnt})
            BYTE_CMD:    w_byte = r_item.command;
            BYTE_ID:     w_byte = r_item.servo_id;
            BYTE_ARG_HI: w_byte = r_item.argument[15:8];
            BYTE_ARG_LO: w_byte = r_item.argument[7:0];
            default:     w_byte = 8'h00;
        endcase
    end

    assign w_crc_next = crc_byte(r_crc, w_byte);
    assign w_done     = r_busy && (r_cnt == 2'(HDR_LEN - 1));
    assign w_push_q   = w_done && i_link_ready.ready;
    assign o_full     = r_busy && !w_push_q;
    assign w_accept   = i_push && !o_full;

    assign o_frame = '{command:  r_item.command,
                       servo_id: r_item.servo_id,
                       argument: r_item.argument,
                       crc:      w_crc_next};
    assign o_link_valid = '{valid: w_done, ready: 1'b0};

    // next state
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_crc  = r_crc;
        n_item = r_item;
        if (r_busy && !w_done) begin
            n_crc = w_crc_next;
            n_cnt = r_cnt + 2'd1;
        end
        if (w_push_q) begin
            n_busy = 1'b0;
        end
        if (w_accept) begin
            n_busy = 1'b1;
            n_cnt  = 2'd0;
            n_crc  = CRC_INIT;
            n_item = i_item;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_crc  <= n_crc;
        r_item <= n_item;
    end

    // a frame that waits for queue space keeps its crc and header
    a_hold_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && !i_link_ready.ready) |=> (r_busy && r_cnt == 2'(HDR_LEN - 1)))
        else $error("front lost a frame while the queue was full");

    // no item is taken while a crc is still running
    a_no_accept_mid_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !w_done) |-> o_full)
        else $error("front accepted an item during the crc");

endmodule

// ===== hw/rtl/scfc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfc_queue
// Short frame queue between the crc front and the byte serializer.
// ----------------------------------------------------------------------------
module scfc_queue #(
    parameter int DEPTH = scfc_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  scfc_pkg::t_frame i_frame,
    input  scfc_pkg::t_link  i_wr,
    output scfc_pkg::t_link  o_wr,
    output scfc_pkg::t_frame o_frame,
    output scfc_pkg::t_link  o_rd,
    input  scfc_pkg::t_link  i_rd
);
    import scfc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_frame          r_mem [DEPTH];
    logic [PW-1:0]   r_wptr, n_wptr;
    logic [PW-1:0]   r_rptr, n_rptr;
    logic [CW-1:0]   r_count, n_count;

    logic            w_wr;
    logic            w_rd;

    assign o_wr    = '{valid: 1'b0, ready: (r_count != CW'(DEPTH))};
    assign o_rd    = '{valid: (r_count != '0), ready: 1'b0};
    assign o_frame = r_mem[r_rptr];
    assign w_wr    = i_wr.valid && o_wr.ready;
    assign w_rd    = i_rd.ready && o_rd.valid;

    // pointer and count update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_wr) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (w_rd) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        case ({w_wr, w_rd})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // frame storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_frame;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_write_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && !w_rd) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue write not counted");

endmodule

// ===== hw/rtl/scfc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfc_back
// Takes finished frames from the queue and sends them one byte a cycle while
// i_pop is held, from a frame register, marking the crc low byte as last.
// ----------------------------------------------------------------------------
module scfc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  scfc_pkg::t_frame   i_frame,
    input  scfc_pkg::t_link    i_q,
    output scfc_pkg::t_link    o_q,
    output logic               o_empty,
    input  logic               i_pop,
    output scfc_pkg::t_out_item o_item
);
    import scfc_pkg::*;

    t_frame      r_frame, n_frame;
    logic [2:0]  r_idx, n_idx;
    logic        r_valid, n_valid;

    logic        w_last;
    logic        w_take;
    logic        w_load;

    assign w_last  = (r_idx == BYTE_CRC_LO);
    assign w_take  = i_pop && r_valid;
    assign w_load  = i_q.valid && (!r_valid || (w_take && w_last));
    assign o_q     = '{valid: 1'b0, ready: w_load};
    assign o_empty = !r_valid;

    // byte select
    always_comb begin
        o_item.last_byte = w_last;
        case (r_idx)
            BYTE_CMD:    o_item.frame_byte = r_frame.command;
            BYTE_ID:     o_item.frame_byte = r_frame.servo_id;
            BYTE_ARG_HI: o_item.frame_byte = r_frame.argument[15:8];
            BYTE_ARG_LO: o_item.frame_byte = r_frame.argument[7:0];
            BYTE_CRC_HI: o_item.frame_byte = r_frame.crc[15:8];
            BYTE_CRC_LO: o_item.frame_byte = r_frame.crc[7:0];
            default:     o_item.frame_byte = 8'h00;
        endcase
    end

    // serializer next state
    always_comb begin
        n_frame = r_frame;
        n_idx   = r_idx;
        n_valid = r_valid;
        if (w_take) begin
            if (w_last) begin
                n_valid = 1'b0;
            end else begin
                n_idx = r_idx + 3'd1;
            end
        end
        if (w_load) begin
            n_frame = i_frame;
            n_idx   = BYTE_CMD;
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= BYTE_CMD;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
    end

    // byte index never runs past the frame
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= BYTE_CRC_LO)
        else $error("byte index out of frame");

    // a waiting frame follows the last byte with no gap
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_last && i_q.valid) |=> (r_valid && r_idx == BYTE_CMD))
        else $error("gap between queued frames");

endmodule

// ===== hw/rtl/servo_command_frame_crc16_core.sv =====
`timescale 1ns / 1ps
// Path: an accepted item runs 3 registered crc byte steps, the 4th step goes
//   with the queue write, then the serializer loads the frame onto the outputs.
// Flow: the result port gives one byte per cycle while pop is held; the front
//   takes a new item once its frame enters the queue of QDEPTH frames.
// Reset: synchronous active-low i_rst_n empties the front, queue and serializer.
// ----------------------------------------------------------------------------
// servo_command_frame_crc16_core
// Builds six-byte servo command frames with a crc-16 trailer and emits them
// one byte per result item.
// ----------------------------------------------------------------------------
module servo_command_frame_crc16_core #(
    parameter int QDEPTH = scfc_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  scfc_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output scfc_pkg::t_out_item o_item
);
    import scfc_pkg::*;

    t_frame w_front_frame;
    t_frame w_q_frame;
    t_link  w_front_link;
    t_link  w_qwr_link;
    t_link  w_qrd_link;
    t_link  w_back_link;

    // crc front end
    scfc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_item       (i_item),
        .o_frame      (w_front_frame),
        .o_link_valid (w_front_link),
        .i_link_ready (w_qwr_link)
    );

    // frame queue
    scfc_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (w_front_frame),
        .i_wr    (w_front_link),
        .o_wr    (w_qwr_link),
        .o_frame (w_q_frame),
        .o_rd    (w_qrd_link),
        .i_rd    (w_back_link)
    );

    // byte serializer
    scfc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (w_q_frame),
        .i_q     (w_qrd_link),
        .o_q     (w_back_link),
        .o_empty (empty),
        .i_pop   (pop),
        .o_item  (o_item)
    );

endmodule
